// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the thermostat checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define THC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define THC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/thc_pkg.sv -----
// ----------------------------------------------------------------------------
// thc_pkg
// Types, codes and constants shared by the thermostat controller modules.
// ----------------------------------------------------------------------------
package thc_pkg;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_HEATING   = 3'd1,
        ST_COOLING   = 3'd2,
        ST_WAIT_HEAT = 3'd3,
        ST_WAIT_COOL = 3'd4,
        ST_FAN_ON    = 3'd5
    } state_t;

    // Operating modes
    localparam logic [2:0] OPM_OFF  = 3'd0;
    localparam logic [2:0] OPM_HEAT = 3'd1;
    localparam logic [2:0] OPM_COOL = 3'd2;
    localparam logic [2:0] OPM_AUTO = 3'd3;
    localparam logic [2:0] OPM_FAN  = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_TARGET    = 3'd1;
    localparam logic [2:0] REG_HYS_ON    = 3'd2;
    localparam logic [2:0] REG_HYS_OFF   = 3'd3;
    localparam logic [2:0] REG_DEADBAND  = 3'd4;
    localparam logic [2:0] REG_MAX_RUN   = 3'd5;
    localparam logic [2:0] REG_TIMEOUT   = 3'd6;

    // Input action codes
    localparam logic ACT_TICK   = 1'b0;
    localparam logic ACT_REPORT = 1'b1;

    // Remote readings at or below -50 F are ignored (sixteenths)
    localparam logic signed [15:0] REMOTE_FLOOR = -16'sd800;

    // Saturation limit of the tick counters
    localparam logic [15:0] TICK_MAX = 16'hFFFF;

    // Configuration register file contents
    typedef struct packed {
        logic [2:0]         mode;
        logic signed [12:0] target;
        logic [7:0]         hys_on;
        logic [7:0]         hys_off;
        logic [8:0]         deadband;
        logic [15:0]        max_run;
        logic [15:0]        timeout;
    } cfg_t;

    // One input request
    typedef struct packed {
        logic               action;
        logic signed [15:0] temperature;
        logic               temp_valid;
        logic               heat_permitted;
        logic               cool_permitted;
    } item_t;

    // One result request
    typedef struct packed {
        logic [2:0]         ctrl_state;
        logic               heat_relay;
        logic               cool_relay;
        logic               fan_relay;
        logic signed [15:0] effective_temp;
        logic               effective_valid;
        logic               using_remote;
        logic               runtime_tripped;
    } result_t;

endpackage

// ----- rtl/thermostat_hysteresis_controller.sv -----
// ----------------------------------------------------------------------------
// thermostat_hysteresis_controller
// Thermostat with hysteresis, auto deadband, remote sensor and run-time limit.
// ----------------------------------------------------------------------------
// Each request is a tick (local sample plus relay permissions) or a remote
// temperature report, and each produces exactly one result. A request sits in
// the input register while the controller state is updated in a single
// pass, and its result is then loaded into the output register. One request
// is accepted every cycle while results are taken, the rate being set by the
// single-pass state update between the two registers. The output register
// lets a new request enter while a result waits to be taken.
// Configuration writes are taken at any cycle the write enable is high and
// must be made only while no request is in flight.
// ----------------------------------------------------------------------------
module thermostat_hysteresis_controller (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // Request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // temperature[15:0], temp_valid[16],
                                   // heat_permitted[17], cool_permitted[18], zero[23:19]
    input  logic [0:0]  s_tuser,   // action[0]
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // ctrl_state[2:0], heat_relay[3], cool_relay[4],
                                   // fan_relay[5], effective_temp[21:6],
                                   // effective_valid[22], using_remote[23],
                                   // runtime_tripped[24], zero[31:25]
);
    import thc_pkg::*;

    cfg_t    cfg;
    logic    mode_change;
    item_t   in_item;
    item_t   in_item_reg;
    logic    in_valid_reg, in_valid_next;
    result_t step_res;
    result_t out_res_reg;
    logic    out_valid_reg, out_valid_next;
    logic    out_load;
    logic    advance;

    thc_cfg_regs u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cfg         (cfg),
        .mode_change (mode_change)
    );

    thc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (advance),
        .item        (in_item_reg),
        .cfg         (cfg),
        .mode_change (mode_change),
        .result      (step_res)
    );

    // Unpack the incoming request
    always_comb
    begin
        in_item.action         = s_tuser[0];
        in_item.temperature    = s_tdata[15:0];
        in_item.temp_valid     = s_tdata[16];
        in_item.heat_permitted = s_tdata[17];
        in_item.cool_permitted = s_tdata[18];
    end

    // Handshake between the two register stages
    assign out_load       = !out_valid_reg || m_tready;
    assign advance        = in_valid_reg && out_load;
    assign s_tready       = !in_valid_reg || out_load;
    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = out_load ? in_valid_reg : out_valid_reg;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_item_reg <= in_item;
        if (advance)
            out_res_reg <= step_res;
    end

    // Pack the result
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0,
                       out_res_reg.runtime_tripped,
                       out_res_reg.using_remote,
                       out_res_reg.effective_valid,
                       out_res_reg.effective_temp,
                       out_res_reg.fan_relay,
                       out_res_reg.cool_relay,
                       out_res_reg.heat_relay,
                       out_res_reg.ctrl_state};

endmodule

// ----- rtl/thc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// thc_cfg_regs
// Configuration register file with write decode and mode-change detect.
// ----------------------------------------------------------------------------
module thc_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic [2:0]    cfg_index,
    input  logic [15:0]   cfg_data,
    output thc_pkg::cfg_t cfg,
    output logic          mode_change
);
    import thc_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] mode_wr;

    // Fold undefined mode codes to off
    assign mode_wr = (cfg_data[2:0] > OPM_FAN) ? OPM_OFF : cfg_data[2:0];

    // Flag a write that really changes the mode
    assign mode_change = cfg_wr_en && (cfg_index == REG_MODE) && (mode_wr != cfg_reg.mode);

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MODE:     cfg_next.mode     = mode_wr;
                REG_TARGET:   cfg_next.target   = cfg_data[12:0];
                REG_HYS_ON:   cfg_next.hys_on   = cfg_data[7:0];
                REG_HYS_OFF:  cfg_next.hys_off  = cfg_data[7:0];
                REG_DEADBAND: cfg_next.deadband = cfg_data[8:0];
                REG_MAX_RUN:  cfg_next.max_run  = cfg_data;
                REG_TIMEOUT:  cfg_next.timeout  = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode     <= OPM_OFF;
            cfg_reg.target   <= 13'sd1088;
            cfg_reg.hys_on   <= 8'd8;
            cfg_reg.hys_off  <= 8'd8;
            cfg_reg.deadband <= 9'd32;
            cfg_reg.max_run  <= 16'd3600;
            cfg_reg.timeout  <= 16'd300;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/thc_core.sv -----
// ----------------------------------------------------------------------------
// thc_core
// Controller state, remote reading store and the per-request decision logic.
// ----------------------------------------------------------------------------
module thc_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  thc_pkg::item_t   item,
    input  thc_pkg::cfg_t    cfg,
    input  logic             mode_change,
    output thc_pkg::result_t result
);
    import thc_pkg::*;

    state_t             state_reg,   state_next;
    logic [15:0]        ticks_reg,   ticks_next;
    logic signed [15:0] remote_reg,  remote_next;
    logic               present_reg, present_next;
    logic [15:0]        age_reg,     age_next;

    logic               fresh;
    logic signed [15:0] eff_temp;
    logic               eff_valid;
    logic               use_remote;
    logic               tripped;
    logic [15:0]        ticks_inc;
    logic               go;
    state_t             go_tgt;
    state_t             go_adj;
    logic signed [19:0] t2, tg2, hon, hoff, db;
    logic signed [19:0] heat2, cool2;

    // Pick the effective temperature
    always_comb
    begin
        fresh = present_reg && (age_reg < cfg.timeout) && (remote_reg > REMOTE_FLOOR);
        if (fresh)
        begin
            eff_temp   = remote_reg;
            eff_valid  = 1'b1;
            use_remote = 1'b1;
        end
        else if (item.temp_valid)
        begin
            eff_temp   = item.temperature;
            eff_valid  = 1'b1;
            use_remote = 1'b0;
        end
        else
        begin
            eff_temp   = 16'sd0;
            eff_valid  = 1'b0;
            use_remote = 1'b0;
        end
    end

    // Compare everything in thirty-seconds of a degree
    assign t2    = {{3{eff_temp[15]}}, eff_temp, 1'b0};
    assign tg2   = {{6{cfg.target[12]}}, cfg.target, 1'b0};
    assign hon   = {11'd0, cfg.hys_on, 1'b0};
    assign hoff  = {11'd0, cfg.hys_off, 1'b0};
    assign db    = {11'd0, cfg.deadband};
    assign heat2 = tg2 - db;
    assign cool2 = tg2 + db;

    assign ticks_inc = (ticks_reg != TICK_MAX) ? ticks_reg + 16'd1 : ticks_reg;

    // Next state
    always_comb
    begin
        go      = 1'b0;
        go_tgt  = ST_IDLE;
        tripped = 1'b0;
        if (!eff_valid)
        begin
            go = (cfg.mode != OPM_OFF) && (cfg.mode != OPM_FAN);
        end
        else if ((state_reg inside {ST_HEATING, ST_COOLING}) && (ticks_inc > cfg.max_run))
        begin
            go      = 1'b1;
            tripped = 1'b1;
        end
        else
        begin
            case (cfg.mode)
                OPM_OFF:
                begin
                    go = 1'b1;
                end
                OPM_FAN:
                begin
                    go     = 1'b1;
                    go_tgt = ST_FAN_ON;
                end
                OPM_HEAT:
                begin
                    if (state_reg inside {ST_IDLE, ST_WAIT_HEAT})
                    begin
                        go     = (t2 <= tg2 - hon);
                        go_tgt = ST_HEATING;
                    end
                    else if (state_reg == ST_HEATING)
                        go = (t2 >= tg2 + hoff);
                    else
                        go = 1'b1;
                end
                OPM_COOL:
                begin
                    if (state_reg inside {ST_IDLE, ST_WAIT_COOL})
                    begin
                        go     = (t2 >= tg2 + hon);
                        go_tgt = ST_COOLING;
                    end
                    else if (state_reg == ST_COOLING)
                        go = (t2 <= tg2 - hoff);
                    else
                        go = 1'b1;
                end
                OPM_AUTO:
                begin
                    if (state_reg inside {ST_IDLE, ST_WAIT_HEAT, ST_WAIT_COOL})
                    begin
                        if (t2 <= heat2 - hon)
                        begin
                            go     = 1'b1;
                            go_tgt = ST_HEATING;
                        end
                        else if (t2 >= cool2 + hon)
                        begin
                            go     = 1'b1;
                            go_tgt = ST_COOLING;
                        end
                    end
                    else if (state_reg == ST_HEATING)
                        go = (t2 >= heat2 + hoff);
                    else if (state_reg == ST_COOLING)
                        go = (t2 <= cool2 - hoff);
                end
                default:
                begin
                    go = 1'b0;
                end
            endcase
        end

        // Divert a refused relay into the matching wait state
        if (go_tgt == ST_HEATING && !item.heat_permitted)
            go_adj = ST_WAIT_HEAT;
        else if (go_tgt == ST_COOLING && !item.cool_permitted)
            go_adj = ST_WAIT_COOL;
        else
            go_adj = go_tgt;

        // Apply the request
        state_next   = state_reg;
        ticks_next   = ticks_reg;
        remote_next  = remote_reg;
        present_next = present_reg;
        age_next     = age_reg;
        if (item.action == ACT_REPORT)
        begin
            remote_next  = item.temperature;
            present_next = item.temp_valid;
            age_next     = 16'd0;
        end
        else
        begin
            age_next = (age_reg != TICK_MAX) ? age_reg + 16'd1 : age_reg;
            if (go && (go_tgt != state_reg))
            begin
                state_next = go_adj;
                ticks_next = 16'd0;
            end
            else
            begin
                ticks_next = ticks_inc;
            end
        end
    end

    // Result fields
    always_comb
    begin
        result.ctrl_state = state_next;
        result.heat_relay = (state_next == ST_HEATING);
        result.cool_relay = (state_next == ST_COOLING);
        result.fan_relay  = (state_next == ST_COOLING) || (state_next == ST_FAN_ON);
        if (item.action == ACT_REPORT)
        begin
            result.effective_temp  = 16'sd0;
            result.effective_valid = 1'b0;
            result.using_remote    = 1'b0;
            result.runtime_tripped = 1'b0;
        end
        else
        begin
            result.effective_temp  = eff_temp;
            result.effective_valid = eff_valid;
            result.using_remote    = use_remote;
            result.runtime_tripped = tripped;
        end
    end

    // Hold the controller state; a mode write drops to idle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ticks_reg   <= 16'd0;
            remote_reg  <= 16'sd0;
            present_reg <= 1'b0;
            age_reg     <= TICK_MAX;
        end
        else if (mode_change)
        begin
            if (state_reg != ST_IDLE)
            begin
                state_reg <= ST_IDLE;
                ticks_reg <= 16'd0;
            end
        end
        else if (step_en)
        begin
            state_reg   <= state_next;
            ticks_reg   <= ticks_next;
            remote_reg  <= remote_next;
            present_reg <= present_next;
            age_reg     <= age_next;
        end
    end

endmodule

// ----- rtl/thc_checker.sv -----
// ----------------------------------------------------------------------------
// thc_checker
// Port-level assertions for the thermostat controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module thc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    import thc_pkg::*;

    // Heat relay drives only in heating
    `THC_ASSERT_IMPL(a_heat_relay, clk, rst_n, m_tvalid, m_tdata[3] == (m_tdata[2:0] == ST_HEATING), "heat relay does not match state")

    // Fan runs in cooling and fan_on only
    `THC_ASSERT_IMPL(a_fan_relay, clk, rst_n, m_tvalid, m_tdata[5] == ((m_tdata[2:0] == ST_COOLING) || (m_tdata[2:0] == ST_FAN_ON)), "fan relay does not match state")

    // A run-time trip lands in idle on a valid temperature
    `THC_ASSERT_IMPL(a_trip_idle, clk, rst_n, m_tvalid && m_tdata[24], (m_tdata[2:0] == ST_IDLE) && m_tdata[22], "trip without idle")

    // No effective reading means no remote source and a zero temperature
    `THC_ASSERT_IMPL(a_invalid_zero, clk, rst_n, m_tvalid && !m_tdata[22], (m_tdata[21:6] == 16'd0) && !m_tdata[23], "invalid reading not cleared")

    // A stalled result holds
    `THC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind thermostat_hysteresis_controller thc_checker u_thc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/sv/thermostat_hysteresis_controller_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// thermostat_hysteresis_controller_tb
// Self-checking bench for the thermostat hysteresis controller.
// ----------------------------------------------------------------------------
// A short table of directed requests covers reset values, extreme readings,
// every mode, the remote floor and timeout, the run-time trip and the
// register write corner cases. Random segments then follow, one register
// setting per segment. Most readings fall near the switching thresholds.
// Each result is compared with a behavioral copy of the controller, or with
// the values its directed row fixes. Both stream sides idle at random in three patterns.
// ----------------------------------------------------------------------------
module thermostat_hysteresis_controller_tb;

    import thc_pkg::*;

    localparam int          SEGMENTS     = 8;
    localparam int          SEG_ITEMS    = 100;
    localparam int          SETTLE       = 4;
    localparam int          MAX_REPORTS  = 40;
    localparam logic [2:0]  MODE_BAD     = 3'd7;
    localparam logic [2:0]  REG_NONE     = 3'd7;

    // One line of the directed table: a register write or a request
    typedef struct {
        bit          is_write;
        logic [2:0]  reg_idx;
        logic [15:0] reg_val;
        item_t       req;
        bit          fixed;
        result_t     want;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    int          send_idle_pct = 26;
    int          recv_idle_pct = 82;
    int          err_count = 0;
    result_t     status_due[$];
    plan_row_t   plan[$];

    // Controller copy: settings
    logic [2:0]         cfg_mode;
    logic signed [12:0] cfg_target;
    logic [7:0]         cfg_hys_on;
    logic [7:0]         cfg_hys_off;
    logic [8:0]         cfg_deadband;
    logic [15:0]        cfg_max_run;
    logic [15:0]        cfg_timeout;

    // Controller copy: state
    state_t             ctl_state;
    logic [15:0]        ctl_ticks;
    logic signed [15:0] remote_temp;
    logic               remote_ok;
    logic [15:0]        remote_age;

    thermostat_hysteresis_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Load the power-on settings and state
    function automatic void thermostat_reset();
        cfg_mode     = OPM_OFF;
        cfg_target   = 13'sd1088;
        cfg_hys_on   = 8'd8;
        cfg_hys_off  = 8'd8;
        cfg_deadband = 9'd32;
        cfg_max_run  = 16'd3600;
        cfg_timeout  = 16'd300;
        ctl_state    = ST_IDLE;
        ctl_ticks    = '0;
        remote_temp  = '0;
        remote_ok    = 1'b0;
        remote_age   = TICK_MAX;
    endfunction

    // Mirror one register write; a mode change drops any active state
    function automatic void thermostat_write(logic [2:0] idx, logic [15:0] val);
        logic [2:0] m;
        case (idx)
            REG_MODE:
            begin
                m = val[2:0];
                if (m > OPM_FAN)
                    m = OPM_OFF;
                if (m != cfg_mode)
                begin
                    cfg_mode = m;
                    if (ctl_state != ST_IDLE)
                    begin
                        ctl_state = ST_IDLE;
                        ctl_ticks = '0;
                    end
                end
            end
            REG_TARGET:   cfg_target   = val[12:0];
            REG_HYS_ON:   cfg_hys_on   = val[7:0];
            REG_HYS_OFF:  cfg_hys_off  = val[7:0];
            REG_DEADBAND: cfg_deadband = val[8:0];
            REG_MAX_RUN:  cfg_max_run  = val;
            REG_TIMEOUT:  cfg_timeout  = val;
            default: ;
        endcase
    endfunction

    // Change state; a refused relay turns heating or cooling into a wait
    function automatic void enter_state(state_t nxt, logic hok, logic cok);
        if (ctl_state == nxt)
            return;
        ctl_ticks = '0;
        if (nxt == ST_HEATING && !hok)
            nxt = ST_WAIT_HEAT;
        else if (nxt == ST_COOLING && !cok)
            nxt = ST_WAIT_COOL;
        ctl_state = nxt;
    endfunction

    // Hysteresis and deadband rules, all compared in thirty-seconds
    function automatic void apply_rules(logic signed [15:0] t, logic hok, logic cok);
        int t2;
        int tg2;
        int hon;
        int hoff;
        int heat2;
        int cool2;
        t2    = 2 * int'(t);
        tg2   = 2 * int'(cfg_target);
        hon   = 2 * int'(cfg_hys_on);
        hoff  = 2 * int'(cfg_hys_off);
        heat2 = tg2 - int'(cfg_deadband);
        cool2 = tg2 + int'(cfg_deadband);
        case (cfg_mode)
            OPM_OFF: enter_state(ST_IDLE, hok, cok);
            OPM_FAN: enter_state(ST_FAN_ON, hok, cok);
            OPM_HEAT:
            begin
                if (ctl_state == ST_IDLE || ctl_state == ST_WAIT_HEAT)
                begin
                    if (t2 <= tg2 - hon)
                        enter_state(ST_HEATING, hok, cok);
                end
                else if (ctl_state == ST_HEATING)
                begin
                    if (t2 >= tg2 + hoff)
                        enter_state(ST_IDLE, hok, cok);
                end
                else
                    enter_state(ST_IDLE, hok, cok);
            end
            OPM_COOL:
            begin
                if (ctl_state == ST_IDLE || ctl_state == ST_WAIT_COOL)
                begin
                    if (t2 >= tg2 + hon)
                        enter_state(ST_COOLING, hok, cok);
                end
                else if (ctl_state == ST_COOLING)
                begin
                    if (t2 <= tg2 - hoff)
                        enter_state(ST_IDLE, hok, cok);
                end
                else
                    enter_state(ST_IDLE, hok, cok);
            end
            default:
            begin
                // Auto: fan_on is left alone
                if (ctl_state == ST_IDLE || ctl_state == ST_WAIT_HEAT ||
                    ctl_state == ST_WAIT_COOL)
                begin
                    if (t2 <= heat2 - hon)
                        enter_state(ST_HEATING, hok, cok);
                    else if (t2 >= cool2 + hon)
                        enter_state(ST_COOLING, hok, cok);
                end
                else if (ctl_state == ST_HEATING)
                begin
                    if (t2 >= heat2 + hoff)
                        enter_state(ST_IDLE, hok, cok);
                end
                else if (ctl_state == ST_COOLING)
                begin
                    if (t2 <= cool2 - hoff)
                        enter_state(ST_IDLE, hok, cok);
                end
            end
        endcase
    endfunction

    // Advance the controller copy by one request and return its status
    function automatic result_t thermostat_step(item_t it);
        result_t            r;
        logic signed [15:0] eff;
        logic               ev;
        logic               ur;
        logic               trip;
        eff  = '0;
        ev   = 1'b0;
        ur   = 1'b0;
        trip = 1'b0;
        if (it.action == ACT_REPORT)
        begin
            remote_temp = it.temperature;
            remote_ok   = it.temp_valid;
            remote_age  = '0;
        end
        else
        begin
            // Pick remote if fresh and above the floor, else the local sample
            if (remote_ok && remote_age < cfg_timeout && remote_temp > REMOTE_FLOOR)
            begin
                eff = remote_temp;
                ev  = 1'b1;
                ur  = 1'b1;
            end
            else if (it.temp_valid)
            begin
                eff = it.temperature;
                ev  = 1'b1;
            end
            if (remote_age != TICK_MAX)
                remote_age++;
            if (ctl_ticks != TICK_MAX)
                ctl_ticks++;
            if (!ev)
            begin
                if (cfg_mode != OPM_OFF && cfg_mode != OPM_FAN)
                    enter_state(ST_IDLE, it.heat_permitted, it.cool_permitted);
            end
            else if ((ctl_state == ST_HEATING || ctl_state == ST_COOLING) &&
                     ctl_ticks > cfg_max_run)
            begin
                enter_state(ST_IDLE, it.heat_permitted, it.cool_permitted);
                trip = 1'b1;
            end
            else
                apply_rules(eff, it.heat_permitted, it.cool_permitted);
        end
        r.ctrl_state      = ctl_state;
        r.heat_relay      = (ctl_state == ST_HEATING);
        r.cool_relay      = (ctl_state == ST_COOLING);
        r.fan_relay       = (ctl_state == ST_COOLING || ctl_state == ST_FAN_ON);
        r.effective_temp  = eff;
        r.effective_valid = ev;
        r.using_remote    = ur;
        r.runtime_tripped = trip;
        return r;
    endfunction

    // Table builders
    function automatic plan_row_t wr(logic [2:0] idx, logic [15:0] val);
        plan_row_t row;
        row = '{default: '0};
        row.is_write = 1'b1;
        row.reg_idx  = idx;
        row.reg_val  = val;
        return row;
    endfunction

    function automatic plan_row_t rq(logic act, logic signed [15:0] t, logic v,
                                     logic h, logic c);
        plan_row_t row;
        row = '{default: '0};
        row.req.action         = act;
        row.req.temperature    = t;
        row.req.temp_valid     = v;
        row.req.heat_permitted = h;
        row.req.cool_permitted = c;
        return row;
    endfunction

    function automatic plan_row_t rq_is(plan_row_t row, state_t st,
                                        logic signed [15:0] eff, logic ev,
                                        logic ur, logic trip);
        row.fixed                = 1'b1;
        row.want.ctrl_state      = st;
        row.want.heat_relay      = (st == ST_HEATING);
        row.want.cool_relay      = (st == ST_COOLING);
        row.want.fan_relay       = (st == ST_COOLING || st == ST_FAN_ON);
        row.want.effective_temp  = eff;
        row.want.effective_valid = ev;
        row.want.using_remote    = ur;
        row.want.runtime_tripped = trip;
        return row;
    endfunction

    // Hold requests until every status has come back, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        thermostat_write(idx, val);
    endtask

    // Offer one request and hold it until accepted
    task automatic send_request(item_t it, bit fixed, result_t want);
        result_t p;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, it.cool_permitted, it.heat_permitted, it.temp_valid,
                     it.temperature};
        s_tuser  <= it.action;
        p = thermostat_step(it);
        status_due.push_back(fixed ? want : p);
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            if (err_count < MAX_REPORTS)
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    // Compare each accepted status with the oldest one due
    task automatic check_status(logic [31:0] d);
        result_t want;
        if (status_due.size() == 0)
        begin
            if (err_count < MAX_REPORTS)
                $display("%0t: unrequested status, expected none, got %h", $time, d);
            err_count++;
        end
        else
        begin
            want = status_due.pop_front();
            check_field("ctrl_state", want.ctrl_state, d[2:0]);
            check_field("heat_relay", want.heat_relay, d[3]);
            check_field("cool_relay", want.cool_relay, d[4]);
            check_field("fan_relay", want.fan_relay, d[5]);
            check_field("effective_temp", want.effective_temp, $signed(d[21:6]));
            check_field("effective_valid", want.effective_valid, d[22]);
            check_field("using_remote", want.using_remote, d[23]);
            check_field("runtime_tripped", want.runtime_tripped, d[24]);
        end
    endtask

    // Status side: check at the edge, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_status(m_tdata);
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Main sequence
    initial
    begin
        item_t   it;
        result_t none;
        int      tgt;
        int      span;
        int      off;
        int      hys_a;
        int      hys_b;
        int      dband;
        int      run_lim;
        int      tmo;
        logic [2:0] mode_val;

        none = '0;
        thermostat_reset();

        // Directed table: power-on mode is off, target 1088
        plan.push_back(rq_is(rq(ACT_TICK, 16'sd1000, 1, 1, 1), ST_IDLE, 16'sd1000, 1, 0, 0));
        plan.push_back(rq_is(rq(ACT_TICK, -16'sd32768, 1, 0, 0), ST_IDLE, -16'sd32768,
                             1, 0, 0));
        plan.push_back(rq_is(rq(ACT_TICK, 16'sh5A5A, 0, 1, 1), ST_IDLE, 16'sd0, 0, 0, 0));
        plan.push_back(rq_is(rq(ACT_REPORT, 16'sd1500, 1, 1, 1), ST_IDLE, 16'sd0, 0, 0, 0));
        plan.push_back(rq_is(rq(ACT_TICK, 16'sd1000, 1, 1, 1), ST_IDLE, 16'sd1500, 1, 1, 0));
        // Heat mode: refused relay waits, invalid reading forces idle
        plan.push_back(wr(REG_MODE, OPM_HEAT));
        plan.push_back(rq_is(rq(ACT_REPORT, 16'sd1000, 0, 1, 1), ST_IDLE, 16'sd0, 0, 0, 0));
        plan.push_back(rq(ACT_TICK, 16'sd1000, 1, 0, 1));
        plan.push_back(rq(ACT_TICK, 16'sd1000, 1, 1, 1));
        plan.push_back(rq_is(rq(ACT_TICK, 16'sd1000, 0, 1, 1), ST_IDLE, 16'sd0, 0, 0, 0));
        // Run-time trip with a run limit of 1
        plan.push_back(wr(REG_MAX_RUN, 16'd1));
        plan.push_back(rq(ACT_TICK, 16'sd1000, 1, 1, 1));
        plan.push_back(rq(ACT_TICK, 16'sd1000, 1, 1, 1));
        plan.push_back(rq_is(rq(ACT_TICK, 16'sd1000, 1, 1, 1), ST_IDLE, 16'sd1000, 1, 0, 1));
        // Cool mode with a refused then granted relay
        plan.push_back(wr(REG_MODE, OPM_COOL));
        plan.push_back(rq(ACT_TICK, 16'sd1200, 1, 1, 0));
        plan.push_back(rq(ACT_TICK, 16'sd1200, 1, 1, 1));
        plan.push_back(wr(REG_MAX_RUN, 16'hFFFF));
        // Remote readings at and just above the floor
        plan.push_back(rq(ACT_REPORT, -16'sd800, 1, 1, 1));
        plan.push_back(rq(ACT_TICK, 16'sd1000, 1, 1, 1));
        plan.push_back(rq(ACT_REPORT, -16'sd799, 1, 1, 1));
        plan.push_back(rq(ACT_TICK, 16'sd1000, 1, 1, 1));
        // Remote goes stale after one tick
        plan.push_back(wr(REG_TIMEOUT, 16'd1));
        plan.push_back(rq(ACT_REPORT, 16'sd1300, 1, 1, 1));
        plan.push_back(rq(ACT_TICK, 16'sd1000, 1, 1, 1));
        plan.push_back(rq(ACT_TICK, 16'sd1000, 1, 1, 1));
        // Auto mode at the reading extremes
        plan.push_back(wr(REG_MODE, OPM_AUTO));
        plan.push_back(rq(ACT_TICK, -16'sd32768, 1, 1, 1));
        plan.push_back(rq(ACT_TICK, 16'sd32767, 1, 1, 1));
        // Fan mode keeps its state on an invalid reading
        plan.push_back(wr(REG_MODE, OPM_FAN));
        plan.push_back(rq(ACT_TICK, 16'sd500, 1, 1, 1));
        plan.push_back(rq_is(rq(ACT_TICK, 16'sd500, 0, 1, 1), ST_FAN_ON, 16'sd0, 0, 0, 0));
        // Out-of-range mode means off; unknown register index is ignored
        plan.push_back(wr(REG_MODE, MODE_BAD));
        plan.push_back(wr(REG_NONE, 16'hFFFF));
        plan.push_back(wr(REG_TIMEOUT, 16'd0));
        plan.push_back(rq_is(rq(ACT_REPORT, 16'sd1500, 1, 1, 1), ST_IDLE, 16'sd0, 0, 0, 0));
        plan.push_back(rq_is(rq(ACT_TICK, 16'sd600, 1, 1, 1), ST_IDLE, 16'sd600, 1, 0, 0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_write)
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            else
                send_request(plan[i].req, plan[i].fixed, plan[i].want);
        end

        // Random segments, one register setting each
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg < 3)
            begin
                send_idle_pct = 26;
                recv_idle_pct = 82;
            end
            else if (seg < 6)
            begin
                send_idle_pct = 82;
                recv_idle_pct = 26;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if ($urandom_range(3) == 0)
                mode_val = 3'($urandom_range(7));
            else
                mode_val = 3'($urandom_range(int'(OPM_AUTO), int'(OPM_HEAT)));
            tgt     = (seg == 0) ? -4096 : (seg == 1) ? 4095 :
                      int'($urandom_range(4800)) - 1600;
            hys_a   = (seg == 2) ? 0 : (seg == 3) ? 255 : int'($urandom_range(40));
            hys_b   = (seg == 3) ? 0 : (seg == 2) ? 255 : int'($urandom_range(40));
            dband   = (seg == 4) ? 0 : (seg == 5) ? 511 : int'($urandom_range(80));
            run_lim = (seg == 6) ? 0 : (seg == 7) ? 65535 : int'($urandom_range(40, 2));
            tmo     = (seg == 0) ? 1 : (seg == 6) ? 65535 : (seg == 7) ? 0 :
                      int'($urandom_range(30, 1));

            // Upper data bits carry noise that the block must drop
            write_reg(REG_TARGET, {3'($urandom), 13'(tgt)});
            write_reg(REG_HYS_ON, {8'($urandom), 8'(hys_a)});
            write_reg(REG_HYS_OFF, {8'($urandom), 8'(hys_b)});
            write_reg(REG_DEADBAND, {7'($urandom), 9'(dband)});
            write_reg(REG_MAX_RUN, 16'(run_lim));
            write_reg(REG_TIMEOUT, 16'(tmo));
            write_reg(REG_MODE, {13'($urandom), mode_val});

            span = dband / 2 + ((hys_a > hys_b) ? hys_a : hys_b) + 16;
            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                // Hold off midway until the pipe is empty
                if (n == SEG_ITEMS / 2)
                    drain();
                it.action = ($urandom_range(99) < 15) ? ACT_REPORT : ACT_TICK;
                if ($urandom_range(9) == 0)
                    it.temperature = 16'($urandom);
                else if (it.action == ACT_REPORT && $urandom_range(9) == 0)
                    it.temperature = 16'(int'(REMOTE_FLOOR) + int'($urandom_range(2)) - 1);
                else
                begin
                    off = int'($urandom_range(2 * span)) - span;
                    it.temperature = 16'(tgt + off);
                end
                it.temp_valid     = ($urandom_range(9) != 0);
                it.heat_permitted = ($urandom_range(4) != 0);
                it.cool_permitted = ($urandom_range(4) != 0);
                send_request(it, 1'b0, none);
            end
        end

        // Wait out the last statuses
        s_tvalid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/thc_pkg.sv
rtl/thc_cfg_regs.sv
rtl/thc_core.sv
rtl/thermostat_hysteresis_controller.sv
rtl/thc_checker.sv
tb/sv/thermostat_hysteresis_controller_tb.sv
